// File: sv/pnfe_pkg.sv
`default_nettype none

package pnfe_pkg;

    // default sizes of the net
    localparam int PLACES_DEF      = 16;
    localparam int TRANSITIONS_DEF = 16;
    localparam int TOKEN_BITS_DEF  = 16;

    // fixed field widths on the ports
    localparam int FIELD_W     = 16;
    localparam int INDEX_W     = 4;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_SET_TOKENS     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ_TOKENS    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WRITE_IN_MASK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE_OUT_MASK = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIRE_ONE       = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SEQ_PASS       = 3'd5;
    localparam logic [FUNC_W-1:0] FN_AVAIL_PASS     = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ENABLED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GUARD_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE         = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PLACES      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_TRANSITIONS = 4'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FIRE1,
        S_SNAP,
        S_PASS,
        S_ENAB,
        S_FINAL
    } pnfe_state_t;

    // commands to the token bank
    typedef struct packed {
        logic set_en;
        logic fire_en;
    } pnfe_bank_cmd_t;

endpackage

`default_nettype wire

// File: sv/pnfe_ram.sv
`default_nettype none

module pnfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/pnfe_token_bank.sv
`default_nettype none

module pnfe_token_bank #(
    parameter int PLACES     = pnfe_pkg::PLACES_DEF,
    parameter int TOKEN_BITS = pnfe_pkg::TOKEN_BITS_DEF,
    localparam int PIW       = (PLACES > 1) ? $clog2(PLACES) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire pnfe_pkg::pnfe_bank_cmd_t        cmd,
    input  wire logic [PIW-1:0]                  set_idx,
    input  wire logic [pnfe_pkg::FIELD_W-1:0]    set_value,
    input  wire logic [PLACES-1:0]               in_mask,
    input  wire logic [PLACES-1:0]               out_mask,
    input  wire logic [PIW-1:0]                  rd_idx,
    output logic      [TOKEN_BITS-1:0]           rd_count,
    output logic      [PLACES-1:0]               nonzero,
    output logic                                 sat_pulse
);

    localparam logic [32:0] MAX_WIDE = (33'd1 << TOKEN_BITS) - 33'd1;
    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

    logic [TOKEN_BITS-1:0] count_reg  [PLACES];
    logic [TOKEN_BITS-1:0] count_next [PLACES];
    logic                  set_big;

    always_comb begin
        logic [TOKEN_BITS-1:0] c;
        c         = '0;
        sat_pulse = 1'b0;
        set_big   = ({17'd0, set_value} > MAX_WIDE);
        for (int p = 0; p < PLACES; p++) begin
            c = count_reg[p];
            if (cmd.fire_en) begin
                // take first, then give: a place on both sides ends unchanged
                if (in_mask[p]) begin
                    if (c == '0) begin
                        sat_pulse = 1'b1;
                    end else begin
                        c = c - TOKEN_BITS'(1);
                    end
                end
                if (out_mask[p]) begin
                    if (c == TOKEN_MAX) begin
                        sat_pulse = 1'b1;
                    end else begin
                        c = c + TOKEN_BITS'(1);
                    end
                end
            end
            if (cmd.set_en && (PIW'(p) == set_idx)) begin
                c = set_big ? TOKEN_MAX : TOKEN_BITS'(set_value);
            end
            count_next[p] = c;
            nonzero[p]    = (count_reg[p] != '0);
        end
        if (cmd.set_en && set_big) begin
            sat_pulse = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PLACES; p++) begin
                count_reg[p] <= '0;
            end
        end else begin
            for (int p = 0; p < PLACES; p++) begin
                count_reg[p] <= count_next[p];
            end
        end
    end

    assign rd_count = count_reg[rd_idx];

endmodule

`default_nettype wire

// File: sv/petri_net_firing_engine_top.sv
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tuser: func; s_tdata: place_index, transition_index,
//         |     |                   |   value, guard
// m_      | out | m_tvalid/m_tready | m_tuser: status; m_tdata: fired_mask, enabled_mask,
//         |     |                   |   token_count, saturated
// cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data (active_places, active_transitions)
//
// a fire one in range tries its transition first, a sequence pass fires in order first, and
// an available pass snapshots enables then fires; an enable scan of the nt active transitions
// comes last; the single evaluate/fire unit visits one transition per cycle
// synchronous active-low reset clears counts, arc valid bits, active sizes, sequencer state and handshakes
// s_tready is high only between words; a stalled result holds in the output register
// while the next word is accepted, and only the final step waits on m_tready
`default_nettype none

module petri_net_firing_engine_top #(
    parameter int PLACES      = pnfe_pkg::PLACES_DEF,
    parameter int TRANSITIONS = pnfe_pkg::TRANSITIONS_DEF,
    parameter int TOKEN_BITS  = pnfe_pkg::TOKEN_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [2:0]                          s_tuser,   // func[2:0]
    // place_index[3:0], transition_index[7:4], value[23:8], guard[39:24]
    input  wire logic [39:0]                         s_tdata,
    // result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [1:0]                               m_tuser,   // status[1:0]
    // fired_mask[15:0], enabled_mask[31:16], token_count[47:32], saturated[48], zero fill
    output logic [55:0]                              m_tdata,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pnfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pnfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PIW = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int TIW = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
    localparam int CPW = $clog2(PLACES + 1);
    localparam int CTW = $clog2(TRANSITIONS + 1);
    localparam int FW  = pnfe_pkg::FIELD_W;

    // input word fields
    logic [2:0]    in_func;
    logic [3:0]    in_pi;
    logic [3:0]    in_ti;
    logic [FW-1:0] in_value;
    logic [FW-1:0] in_guard;
    logic          s_accept;

    assign in_func  = s_tuser;
    assign in_pi    = s_tdata[3:0];
    assign in_ti    = s_tdata[7:4];
    assign in_value = s_tdata[23:8];
    assign in_guard = s_tdata[39:24];
    assign s_accept = s_tvalid && s_tready;

    // sequencer and item state
    pnfe_pkg::pnfe_state_t state_reg, state_next;
    logic [CTW-1:0]         t_reg, t_next;
    logic [CPW-1:0]         np_reg;
    logic [CTW-1:0]         nt_reg;
    logic [2:0]             func_reg;
    logic [3:0]             pi_reg;
    logic [3:0]             ti_reg;
    logic [FW-1:0]          guard_reg;
    logic [1:0]             status_reg, status_next;
    logic [TRANSITIONS-1:0] fired_reg, fired_next;
    logic [TRANSITIONS-1:0] enab_reg, enab_next;
    logic [TRANSITIONS-1:0] snap_reg, snap_next;
    logic                   sat_reg, sat_next;
    logic [TRANSITIONS-1:0] in_vld_reg, out_vld_reg;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [55:0] m_data_reg;
    logic        out_load;

    // datapath
    logic [TIW-1:0]         t_idx;
    logic [TIW-1:0]         rd_addr;
    logic [PLACES-1:0]      place_act;
    logic [PLACES-1:0]      in_rdata, out_rdata;
    logic [PLACES-1:0]      in_mask_eff, out_mask_eff;
    logic [PLACES-1:0]      nonzero;
    logic [TRANSITIONS-1:0] guard_ext;
    logic                   t_en;
    logic                   t_guard;
    logic                   t_last;
    logic                   fire_cond;
    logic                   pi_ok_in, ti_ok_in, pi_ok;
    logic                   in_we, out_we;
    logic [TOKEN_BITS-1:0]  rd_count;
    logic                   sat_pulse;
    pnfe_pkg::pnfe_bank_cmd_t bank_cmd;

    assign t_idx    = t_reg[TIW-1:0];
    assign rd_addr  = t_next[TIW-1:0];
    assign pi_ok_in = (in_pi < np_reg);
    assign ti_ok_in = (in_ti < nt_reg);
    assign pi_ok    = (pi_reg < np_reg);
    assign t_last   = ((t_reg + CTW'(1)) == nt_reg);

    always_comb begin
        for (int p = 0; p < PLACES; p++) begin
            place_act[p] = (CPW'(p) < np_reg);
        end
        for (int t = 0; t < TRANSITIONS; t++) begin
            guard_ext[t] = (t < FW) ? guard_reg[t % FW] : 1'b0;
        end
    end

    // arcs to inactive places and never-written entries drop out here
    assign in_mask_eff  = in_rdata & place_act & {PLACES{in_vld_reg[t_idx]}};
    assign out_mask_eff = out_rdata & place_act & {PLACES{out_vld_reg[t_idx]}};
    assign t_en         = &(~in_mask_eff | nonzero);
    assign t_guard      = guard_ext[t_idx];

    always_comb begin
        fire_cond = 1'b0;
        case (state_reg)
            pnfe_pkg::S_FIRE1: fire_cond = t_en && t_guard;
            pnfe_pkg::S_PASS: begin
                fire_cond = t_en && t_guard &&
                            ((func_reg != pnfe_pkg::FN_AVAIL_PASS) || snap_reg[t_idx]);
            end
            default: fire_cond = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        t_next      = t_reg;
        status_next = status_reg;
        fired_next  = fired_reg;
        enab_next   = enab_reg;
        snap_next   = snap_reg;
        sat_next    = sat_reg | sat_pulse;
        case (state_reg)
            pnfe_pkg::S_IDLE: begin
                if (s_accept) begin
                    fired_next  = '0;
                    enab_next   = '0;
                    snap_next   = '0;
                    sat_next    = sat_pulse;
                    status_next = pnfe_pkg::ST_OK;
                    case (in_func)
                        pnfe_pkg::FN_SET_TOKENS, pnfe_pkg::FN_READ_TOKENS: begin
                            if (!pi_ok_in) begin
                                status_next = pnfe_pkg::ST_RANGE;
                            end
                        end
                        pnfe_pkg::FN_WRITE_IN_MASK, pnfe_pkg::FN_WRITE_OUT_MASK,
                        pnfe_pkg::FN_FIRE_ONE: begin
                            if (!ti_ok_in) begin
                                status_next = pnfe_pkg::ST_RANGE;
                            end
                        end
                        default: status_next = pnfe_pkg::ST_OK;
                    endcase
                    state_next = pnfe_pkg::S_PREP;
                end
            end
            pnfe_pkg::S_PREP: begin
                t_next = '0;
                if ((func_reg == pnfe_pkg::FN_FIRE_ONE) &&
                    (status_reg == pnfe_pkg::ST_OK)) begin
                    t_next     = CTW'(ti_reg);
                    state_next = pnfe_pkg::S_FIRE1;
                end else if (nt_reg == '0) begin
                    state_next = pnfe_pkg::S_FINAL;
                end else if (func_reg == pnfe_pkg::FN_SEQ_PASS) begin
                    state_next = pnfe_pkg::S_PASS;
                end else if (func_reg == pnfe_pkg::FN_AVAIL_PASS) begin
                    state_next = pnfe_pkg::S_SNAP;
                end else begin
                    state_next = pnfe_pkg::S_ENAB;
                end
            end
            pnfe_pkg::S_FIRE1: begin
                // not enabled wins over a refused guard
                if (!t_en) begin
                    status_next = pnfe_pkg::ST_NOT_ENABLED;
                end else if (!t_guard) begin
                    status_next = pnfe_pkg::ST_GUARD_REFUSED;
                end else begin
                    fired_next[t_idx] = 1'b1;
                end
                t_next     = '0;
                state_next = pnfe_pkg::S_ENAB;
            end
            pnfe_pkg::S_SNAP: begin
                snap_next[t_idx] = t_en;
                if (t_last) begin
                    t_next     = '0;
                    state_next = pnfe_pkg::S_PASS;
                end else begin
                    t_next = t_reg + CTW'(1);
                end
            end
            pnfe_pkg::S_PASS: begin
                if (fire_cond) begin
                    fired_next[t_idx] = 1'b1;
                end
                if (t_last) begin
                    t_next     = '0;
                    state_next = pnfe_pkg::S_ENAB;
                end else begin
                    t_next = t_reg + CTW'(1);
                end
            end
            pnfe_pkg::S_ENAB: begin
                enab_next[t_idx] = t_en;
                if (t_last) begin
                    t_next     = '0;
                    state_next = pnfe_pkg::S_FINAL;
                end else begin
                    t_next = t_reg + CTW'(1);
                end
            end
            pnfe_pkg::S_FINAL: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = pnfe_pkg::S_IDLE;
                end
            end
            default: state_next = pnfe_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready         = (state_reg == pnfe_pkg::S_IDLE);
        cfg_ready        = 1'b1;
        bank_cmd.set_en  = s_accept && (in_func == pnfe_pkg::FN_SET_TOKENS) && pi_ok_in;
        bank_cmd.fire_en = fire_cond;
        in_we            = s_accept && (in_func == pnfe_pkg::FN_WRITE_IN_MASK) && ti_ok_in;
        out_we           = s_accept && (in_func == pnfe_pkg::FN_WRITE_OUT_MASK) && ti_ok_in;
        out_load         = (state_reg == pnfe_pkg::S_FINAL) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pnfe_pkg::S_IDLE;
            t_reg       <= '0;
            np_reg      <= '0;
            nt_reg      <= '0;
            in_vld_reg  <= '0;
            out_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            t_reg     <= t_next;
            // oversized settings clamp to the built size
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == pnfe_pkg::REG_ACTIVE_PLACES) begin
                    np_reg <= (32'(cfg_data) > PLACES) ? CPW'(PLACES) : CPW'(cfg_data);
                end else if (cfg_index == pnfe_pkg::REG_ACTIVE_TRANSITIONS) begin
                    nt_reg <= (32'(cfg_data) > TRANSITIONS) ? CTW'(TRANSITIONS)
                                                            : CTW'(cfg_data);
                end
            end
            if (in_we) begin
                in_vld_reg[TIW'(in_ti)] <= 1'b1;
            end
            if (out_we) begin
                out_vld_reg[TIW'(in_ti)] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= in_func;
            pi_reg    <= in_pi;
            ti_reg    <= in_ti;
            guard_reg <= in_guard;
        end
        status_reg <= status_next;
        fired_reg  <= fired_next;
        enab_reg   <= enab_next;
        snap_reg   <= snap_next;
        sat_reg    <= sat_next;
        if (out_load) begin
            m_status_reg <= status_reg;
            m_data_reg   <= {7'd0, sat_reg,
                             pi_ok ? FW'(rd_count) : FW'(0),
                             FW'(enab_reg), FW'(fired_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

    pnfe_ram #(
        .WIDTH (PLACES),
        .DEPTH (TRANSITIONS)
    ) u_in_ram (
        .aclk  (aclk),
        .we    (in_we),
        .waddr (TIW'(in_ti)),
        .wdata (PLACES'(in_value)),
        .raddr (rd_addr),
        .rdata (in_rdata)
    );

    pnfe_ram #(
        .WIDTH (PLACES),
        .DEPTH (TRANSITIONS)
    ) u_out_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (TIW'(in_ti)),
        .wdata (PLACES'(in_value)),
        .raddr (rd_addr),
        .rdata (out_rdata)
    );

    pnfe_token_bank #(
        .PLACES     (PLACES),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (bank_cmd),
        .set_idx   (PIW'(in_pi)),
        .set_value (in_value),
        .in_mask   (in_mask_eff),
        .out_mask  (out_mask_eff),
        .rd_idx    (PIW'(pi_reg)),
        .rd_count  (rd_count),
        .nonzero   (nonzero),
        .sat_pulse (sat_pulse)
    );

endmodule

`default_nettype wire

// File: sv/pnfe_checker.sv
`default_nettype none

module pnfe_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [1:0]                       m_tuser,
    input wire logic [55:0]                      m_tdata
);

    // block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again in the cycle after an accept");

    // no result can come out of nothing the cycle after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result shown one cycle after accept");

    // refused or out-of-range words fire nothing
    a_refused_fires_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pnfe_pkg::ST_OK) |-> (m_tdata[15:0] == 16'd0))
        else $error("transition fired with a failing status");

    // pending result holds its word
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind petri_net_firing_engine_top pnfe_checker u_checker (.*);

`default_nettype wire
